### sv/efb_pkg.sv
// ----------------------------------------------------------------------------
// efb_pkg
// Shared types and constants for the escaped frame builder.
// ----------------------------------------------------------------------------
package efb_pkg;

  // Item kinds carried on the input tuser.
  localparam logic [1:0] ACT_HEADER  = 2'd0;
  localparam logic [1:0] ACT_PAYLOAD = 2'd1;
  localparam logic [1:0] ACT_TRAILER = 2'd2;
  localparam logic [1:0] ACT_NONE    = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_LOCAL_HIGH = 2'd0;
  localparam logic [1:0] REG_LOCAL_LOW  = 2'd1;
  localparam logic [1:0] REG_DIRECT     = 2'd2;

  // Framing bytes.
  localparam logic [7:0] START_BYTE   = 8'h01;
  localparam logic [7:0] END_BYTE     = 8'h04;
  localparam logic [7:0] ESC_BYTE     = 8'h1B;
  localparam logic [7:0] ZERO_CHANNEL = 8'h00;
  localparam logic [7:0] DIRECT_COUNT = 8'h10;
  localparam logic [7:0] RESET_ADDR   = 8'h02;

  // Symbol positions within one item.
  localparam logic [3:0] HDR_LAST_IDX = 4'd10;
  localparam logic [3:0] TRL_LAST_IDX = 4'd1;

  // Default depth of the symbol queue.
  localparam int FIFO_DEPTH = 4;

  // Live configuration.
  typedef struct packed {
    logic [7:0] local_high;
    logic [7:0] local_low;
    logic       direct;
  } cfg_t;

  // One symbol: a byte, whether it is subject to escaping, and whether it
  // closes the item.
  typedef struct packed {
    logic [7:0] data;
    logic       esc;
    logic       last;
  } sym_t;

endpackage

### sv/escaped_frame_builder.sv
// ----------------------------------------------------------------------------
// escaped_frame_builder
// Byte-stuffing radio link framer with an escape character.
// ----------------------------------------------------------------------------
// Each input transaction is one step of a frame: a header (tuser 0), a
// payload byte (tuser 1) or a trailer carrying the CRC (tuser 2); tuser 3 is
// dropped with no output. The front part turns an item into symbols at one
// per cycle while the queue has room, a short queue holds them, and the back
// part sends one link byte per cycle while the output is taken, putting 0x1B
// before any escaped byte equal to 0x01, 0x04 or 0x1B. A payload item thus
// yields one or two bytes, a trailer two or three, and a header 11 to 18; the
// front accepts a new item as soon as the last symbol of the previous one
// enters the queue. tlast marks the final byte of each item.
// Configuration is read live and should be written only while idle.
// ----------------------------------------------------------------------------
module escaped_frame_builder #(
  parameter int FIFO_DEPTH = efb_pkg::FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  // dest_addr_high, dest_addr_low, dest_channel, src_addr_high, src_addr_low,
  // src_channel, count_byte, payload_byte, crc_byte (8 bits each, low first)
  input  logic [71:0] s_tdata,
  // action
  input  logic [1:0]  s_tuser,
  // Output stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_byte
  output logic [7:0]  m_tdata,
  // last
  output logic        m_tlast
);
  import efb_pkg::*;

  cfg_t cfg;
  sym_t front_sym;
  sym_t queue_sym;
  logic front_valid;
  logic queue_full;
  logic queue_empty;
  logic queue_pop;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.local_high <= RESET_ADDR;
      cfg.local_low  <= RESET_ADDR;
      cfg.direct     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOCAL_HIGH: cfg.local_high <= cfg_data;
        REG_LOCAL_LOW:  cfg.local_low  <= cfg_data;
        REG_DIRECT:     cfg.direct     <= cfg_data[0];
        default:        cfg.direct     <= cfg.direct;
      endcase
    end
  end

  // Front: accepts and breaks items into symbols.
  efb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .sym_valid (front_valid),
    .sym       (front_sym),
    .sym_full  (queue_full)
  );

  // Symbol queue.
  efb_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (front_valid),
    .wr_data (front_sym),
    .full    (queue_full),
    .rd_en   (queue_pop),
    .rd_data (queue_sym),
    .empty   (queue_empty)
  );

  // Back: escaping and output register.
  efb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .sym       (queue_sym),
    .sym_empty (queue_empty),
    .sym_pop   (queue_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

### sv/efb_front.sv
// ----------------------------------------------------------------------------
// efb_front
// Accepts input transactions and breaks each item into a run of symbols.
// ----------------------------------------------------------------------------
module efb_front (
  input  logic               clk,
  input  logic               rst,
  input  efb_pkg::cfg_t      cfg,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [71:0]        s_tdata,
  input  logic [1:0]         s_tuser,
  output logic               sym_valid,
  output efb_pkg::sym_t      sym,
  input  logic               sym_full
);
  import efb_pkg::*;

  logic       busy;
  logic [3:0] idx;
  logic [1:0] action;
  logic [7:0] dh, dl, dc, sh, sl, sc, cnt, pay, crc;
  logic       accept;
  logic       push;
  logic       at_last;
  logic       to_dest;

  // Symbol emission handshake with the queue.
  assign push     = busy && !sym_full;
  assign s_tready = !busy || (push && at_last);
  assign accept   = s_tvalid && s_tready;
  assign sym_valid = busy;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (accept) begin
      busy <= (s_tuser != ACT_NONE);
      idx  <= '0;
    end else if (push) begin
      if (at_last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 4'd1;
      end
    end
  end

  // Item fields, held while the item is broken up.
  always_ff @(posedge clk) begin
    if (accept) begin
      action <= s_tuser;
      dh     <= s_tdata[7:0];
      dl     <= s_tdata[15:8];
      dc     <= s_tdata[23:16];
      sh     <= s_tdata[31:24];
      sl     <= s_tdata[39:32];
      sc     <= s_tdata[47:40];
      cnt    <= s_tdata[55:48];
      pay    <= s_tdata[63:56];
      crc    <= s_tdata[71:64];
    end
  end

  // The destination is the next hop in direct mode or inside the local cluster.
  assign to_dest = cfg.direct || (dh == cfg.local_high && dl == cfg.local_low);

  // Last symbol position of the current item.
  always_comb begin
    case (action)
      ACT_HEADER:  at_last = (idx == HDR_LAST_IDX);
      ACT_TRAILER: at_last = (idx == TRL_LAST_IDX);
      default:     at_last = 1'b1;
    endcase
  end

  // Symbol selection for the current position.
  always_comb begin
    sym.data = pay;
    sym.esc  = 1'b1;
    sym.last = at_last;
    case (action)
      ACT_HEADER: begin
        case (idx)
          4'd0: begin
            sym.data = to_dest ? dh : cfg.local_high;
            sym.esc  = 1'b0;
          end
          4'd1: begin
            sym.data = to_dest ? dl : cfg.local_low;
            sym.esc  = 1'b0;
          end
          4'd2: begin
            sym.data = to_dest ? dc : ZERO_CHANNEL;
            sym.esc  = 1'b0;
          end
          4'd3: begin
            sym.data = START_BYTE;
            sym.esc  = 1'b0;
          end
          4'd4:    sym.data = cfg.direct ? DIRECT_COUNT : cnt;
          4'd5:    sym.data = sh;
          4'd6:    sym.data = sl;
          4'd7:    sym.data = sc;
          4'd8:    sym.data = dh;
          4'd9:    sym.data = dl;
          default: sym.data = dc;
        endcase
      end
      ACT_TRAILER: begin
        if (idx == '0) begin
          sym.data = crc;
        end else begin
          sym.data = END_BYTE;
          sym.esc  = 1'b0;
        end
      end
      default: sym.data = pay;
    endcase
  end

endmodule

### sv/efb_fifo.sv
// ----------------------------------------------------------------------------
// efb_fifo
// Short symbol queue between the front and back parts.
// ----------------------------------------------------------------------------
module efb_fifo #(
  parameter int DEPTH = efb_pkg::FIFO_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  efb_pkg::sym_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output efb_pkg::sym_t rd_data,
  output logic          empty
);
  import efb_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sym_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entries[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

### sv/efb_back.sv
// ----------------------------------------------------------------------------
// efb_back
// Expands queued symbols into link bytes, inserting escapes as needed.
// ----------------------------------------------------------------------------
module efb_back (
  input  logic          clk,
  input  logic          rst,
  input  efb_pkg::sym_t sym,
  input  logic          sym_empty,
  output logic          sym_pop,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [7:0]    m_tdata,
  output logic          m_tlast
);
  import efb_pkg::*;

  logic esc_sent;
  logic load_ok;
  logic special;
  logic need_esc;
  logic emit;

  // A byte may enter the output register when it is empty or being taken.
  assign load_ok  = !m_tvalid || m_tready;
  assign special  = (sym.data == START_BYTE) || (sym.data == END_BYTE) ||
                    (sym.data == ESC_BYTE);
  assign need_esc = sym.esc && special && !esc_sent;
  assign emit     = load_ok && !sym_empty;
  assign sym_pop  = emit && !need_esc;

  // Control: output valid and the escape phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      esc_sent <= 1'b0;
    end else if (load_ok) begin
      m_tvalid <= !sym_empty;
      if (emit) begin
        esc_sent <= need_esc;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= need_esc ? ESC_BYTE : sym.data;
      m_tlast <= need_esc ? 1'b0 : sym.last;
    end
  end

endmodule
